FILE: rtl/core/affine_vertex_transform_core_assert.svh
// ----------------------------------------------------------------------------
// affine vertex transform core assertion macros
// shared property wrappers, clocked on the rising edge, off while in reset
// ----------------------------------------------------------------------------
`ifndef AFFINE_VERTEX_TRANSFORM_CORE_ASSERT_SVH
`define AFFINE_VERTEX_TRANSFORM_CORE_ASSERT_SVH

// same-cycle implication
`define AVT_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AVT_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/avt_pkg.sv
// ----------------------------------------------------------------------------
// avt_pkg
// widths, register codes and lane types of the affine vertex transform core
// ----------------------------------------------------------------------------
`default_nettype none

package avt_pkg;

    localparam int WORD_W    = 32;
    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int NUM_LANES = 3;
    localparam int NUM_REGS  = 6;
    localparam int CFG_IDX_W = 3;
    localparam int REG_W     = 2 * WORD_W;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int ACC_W     = SUM_W - FRAC_W + 1;
    localparam int TDATA_W   = NUM_LANES * WORD_W;
    localparam int PIPE_D    = 3;

    localparam logic [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] DATA_MIN = ~DATA_MAX;
    localparam logic [WORD_W-1:0] ONE_WORD = WORD_W'(1) << FRAC_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0_COLS01 = 3'd0,
        REG_ROW0_COLS23 = 3'd1,
        REG_ROW1_COLS01 = 3'd2,
        REG_ROW1_COLS23 = 3'd3,
        REG_ROW2_COLS01 = 3'd4,
        REG_ROW2_COLS23 = 3'd5
    } cfg_reg_t;

    // one matrix row: three column coefficients and the translation term
    typedef struct packed {
        logic signed [DATA_W-1:0] trans;
        logic signed [DATA_W-1:0] c2;
        logic signed [DATA_W-1:0] c1;
        logic signed [DATA_W-1:0] c0;
    } row_coef_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] z;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] x;
    } point_t;

    typedef struct packed {
        logic                     clip;
        logic signed [DATA_W-1:0] val;
    } lane_result_t;

endpackage

`default_nettype wire

FILE: rtl/core/avt_lane.sv
// ----------------------------------------------------------------------------
// avt_lane
// one matrix row: multiply, sum, shift, add translation and saturate
// ----------------------------------------------------------------------------
`default_nettype none

module avt_lane (
    input  wire logic                 aclk,
    input  wire logic                 adv,
    input  wire avt_pkg::row_coef_t   coef,
    input  wire avt_pkg::point_t      point,
    output avt_pkg::lane_result_t     result
);
    import avt_pkg::*;

    logic signed [PROD_W-1:0] prod0_reg, prod1_reg, prod2_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    lane_result_t             res_reg;

    logic signed [SUM_W-FRAC_W-1:0] shifted;
    logic signed [ACC_W-1:0]        acc;
    logic                           ovf;
    lane_result_t                   res_next;

    // floor shift is the plain upper slice of the exact sum
    always_comb begin
        shifted      = $signed(sum_reg[SUM_W-1:FRAC_W]);
        acc          = ACC_W'(shifted) + ACC_W'(coef.trans);
        ovf          = (acc[ACC_W-1:DATA_W-1] != {(ACC_W-DATA_W+1){acc[ACC_W-1]}});
        res_next.clip = ovf;
        if (ovf) begin
            res_next.val = acc[ACC_W-1] ? DATA_MIN : DATA_MAX;
        end else begin
            res_next.val = acc[DATA_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod0_reg <= PROD_W'(coef.c0) * PROD_W'(point.x);
            prod1_reg <= PROD_W'(coef.c1) * PROD_W'(point.y);
            prod2_reg <= PROD_W'(coef.c2) * PROD_W'(point.z);
            sum_reg   <= SUM_W'(prod0_reg) + SUM_W'(prod1_reg) + SUM_W'(prod2_reg);
            res_reg   <= res_next;
        end
    end

    assign result = res_reg;

endmodule

`default_nettype wire

FILE: rtl/core/avt_merge.sv
// ----------------------------------------------------------------------------
// avt_merge
// joins the lane results into one transfer, output register plus skid slot
// ----------------------------------------------------------------------------
`default_nettype none

module avt_merge (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire avt_pkg::lane_result_t [avt_pkg::NUM_LANES-1:0] lanes,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [avt_pkg::TDATA_W-1:0]         m_tdata,  // out_x, out_y, out_z
    output logic [0:0]                          m_tuser   // clipped
);
    import avt_pkg::*;

    localparam int ITEM_W = TDATA_W + 1;

    logic              out_vld_reg, out_vld_next;
    logic [ITEM_W-1:0] out_dat_reg, out_dat_next;
    logic              skid_vld_reg, skid_vld_next;
    logic [ITEM_W-1:0] skid_dat_reg, skid_dat_next;
    logic [ITEM_W-1:0] in_item;
    logic              in_xfer;
    logic              any_clip;

    always_comb begin
        any_clip = 1'b0;
        for (int i = 0; i < NUM_LANES; i++) begin
            any_clip = any_clip | lanes[i].clip;
            in_item[i*WORD_W +: WORD_W] = WORD_W'(lanes[i].val);
        end
        in_item[TDATA_W] = any_clip;
    end

    assign in_ready = !skid_vld_reg;
    assign in_xfer  = in_valid && in_ready;

    always_comb begin
        out_vld_next  = out_vld_reg;
        out_dat_next  = out_dat_reg;
        skid_vld_next = skid_vld_reg;
        skid_dat_next = skid_dat_reg;
        if (!out_vld_reg || m_tready) begin
            out_vld_next  = skid_vld_reg || in_xfer;
            out_dat_next  = skid_vld_reg ? skid_dat_reg : in_item;
            skid_vld_next = 1'b0;
        end else if (in_xfer) begin
            skid_vld_next = 1'b1;
            skid_dat_next = in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
        out_dat_reg  <= out_dat_next;
        skid_dat_reg <= skid_dat_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_dat_reg[TDATA_W-1:0];
    assign m_tuser  = out_dat_reg[TDATA_W +: 1];

endmodule

`default_nettype wire

FILE: rtl/core/affine_vertex_transform_core.sv
// throughput: one point per clock, a new point may follow every cycle unless stalled
// path: an input transfer passes the multiply, sum and shift/saturate
//   stages of each row lane, then the output register, to m_tvalid
// a stalled output holds the lanes; one point parks in the skid slot
// reset (aresetn low, synchronous) clears all valid bits and loads identity
// ----------------------------------------------------------------------------
// affine_vertex_transform_core
// 3-D point times the upper three rows of a 4x4 Q16.16 matrix, w taken as 1
// ----------------------------------------------------------------------------
`default_nettype none

`include "affine_vertex_transform_core_assert.svh"

module affine_vertex_transform_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input points
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [avt_pkg::TDATA_W-1:0]       s_tdata,   // in_x, in_y, in_z
    // transformed points
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [avt_pkg::TDATA_W-1:0]            m_tdata,   // out_x, out_y, out_z
    output logic [0:0]                             m_tuser,   // clipped
    // matrix register writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [avt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [avt_pkg::REG_W-1:0]         cfg_data
);
    import avt_pkg::*;

    // matrix rows 0..2, two words per register (low word first column)
    logic [REG_W-1:0]  coef_reg [NUM_REGS];
    // one valid bit per lane stage, shared by all three lanes
    logic [PIPE_D-1:0] pipe_vld_reg;

    logic         s_xfer;
    logic         adv;
    point_t       point;
    row_coef_t    row_coef [NUM_LANES];
    lane_result_t [NUM_LANES-1:0] lane_res;

    // writes are always taken; indexes past the last register are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg[REG_ROW0_COLS01] <= {WORD_W'(0), ONE_WORD};
            coef_reg[REG_ROW0_COLS23] <= REG_W'(0);
            coef_reg[REG_ROW1_COLS01] <= {ONE_WORD, WORD_W'(0)};
            coef_reg[REG_ROW1_COLS23] <= REG_W'(0);
            coef_reg[REG_ROW2_COLS01] <= REG_W'(0);
            coef_reg[REG_ROW2_COLS23] <= {WORD_W'(0), ONE_WORD};
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_ROW0_COLS01: coef_reg[REG_ROW0_COLS01] <= cfg_data;
                REG_ROW0_COLS23: coef_reg[REG_ROW0_COLS23] <= cfg_data;
                REG_ROW1_COLS01: coef_reg[REG_ROW1_COLS01] <= cfg_data;
                REG_ROW1_COLS23: coef_reg[REG_ROW1_COLS23] <= cfg_data;
                REG_ROW2_COLS01: coef_reg[REG_ROW2_COLS01] <= cfg_data;
                REG_ROW2_COLS23: coef_reg[REG_ROW2_COLS23] <= cfg_data;
                default: ;
            endcase
        end
    end

    // only the low DATA_W bits of each 32-bit word are used
    assign point.x = s_tdata[0*WORD_W +: DATA_W];
    assign point.y = s_tdata[1*WORD_W +: DATA_W];
    assign point.z = s_tdata[2*WORD_W +: DATA_W];

    // the whole lane pipeline moves while the merge stage has room;
    // that ready comes straight from a register in the merge stage
    assign s_tready = adv;
    assign s_xfer   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pipe_vld_reg <= '0;
        end else if (adv) begin
            pipe_vld_reg <= {pipe_vld_reg[PIPE_D-2:0], s_xfer};
        end
    end

    // one lane per matrix row
    for (genvar r = 0; r < NUM_LANES; r++) begin : g_lane
        assign row_coef[r].c0    = coef_reg[2*r][DATA_W-1:0];
        assign row_coef[r].c1    = coef_reg[2*r][WORD_W +: DATA_W];
        assign row_coef[r].c2    = coef_reg[2*r+1][DATA_W-1:0];
        assign row_coef[r].trans = coef_reg[2*r+1][WORD_W +: DATA_W];

        avt_lane u_lane (
            .aclk   (aclk),
            .adv    (adv),
            .coef   (row_coef[r]),
            .point  (point),
            .result (lane_res[r])
        );
    end

    // packs x, y, z and the clip flag into one output transfer
    avt_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (pipe_vld_reg[PIPE_D-1]),
        .in_ready (adv),
        .lanes    (lane_res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // ---- assertions --------------------------------------------------------
    logic [WORD_W-1:0] sat_hi_w;
    logic [WORD_W-1:0] sat_lo_w;
    logic              sat_seen;

    assign sat_hi_w = WORD_W'($signed(DATA_MAX));
    assign sat_lo_w = WORD_W'($signed(DATA_MIN));
    assign sat_seen = (m_tdata[0*WORD_W +: WORD_W] == sat_hi_w)
                   || (m_tdata[0*WORD_W +: WORD_W] == sat_lo_w)
                   || (m_tdata[1*WORD_W +: WORD_W] == sat_hi_w)
                   || (m_tdata[1*WORD_W +: WORD_W] == sat_lo_w)
                   || (m_tdata[2*WORD_W +: WORD_W] == sat_hi_w)
                   || (m_tdata[2*WORD_W +: WORD_W] == sat_lo_w);

    // input back-pressure only while a result is waiting at the output
    `AVT_ASSERT_IMP(a_stall_has_output, aclk, aresetn, !s_tready, m_tvalid,
        "input stalled with no result at the output")
    // an input transfer enters the first lane stage
    `AVT_ASSERT_NXT(a_xfer_enters_lane, aclk, aresetn, s_xfer, pipe_vld_reg[0],
        "accepted point lost before the first lane stage")
    // a stalled last stage keeps its point
    `AVT_ASSERT_NXT(a_stall_holds_lane, aclk, aresetn,
        pipe_vld_reg[PIPE_D-1] && !s_tready, pipe_vld_reg[PIPE_D-1],
        "point dropped from the last lane stage during a stall")
    // a clipped result carries at least one clamped component
    `AVT_ASSERT_IMP(a_clip_clamped, aclk, aresetn, m_tvalid && m_tuser[0], sat_seen,
        "clipped flag set without a clamped component")

endmodule

`default_nettype wire

FILE: tb/affine_vertex_transform_core_checker.sv
// ----------------------------------------------------------------------------
// affine vertex transform core checker
// tracks the matrix registers, predicts each transformed point and compares
// ----------------------------------------------------------------------------
module affine_vertex_transform_core_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [avt_pkg::TDATA_W-1:0]   s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [avt_pkg::TDATA_W-1:0]   m_tdata,
    input  logic [0:0]                    m_tuser,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [avt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [avt_pkg::REG_W-1:0]     cfg_data,
    output int                            mismatches,
    output int                            points_pending
);
    import avt_pkg::*;

    // wide enough for three full products plus the translation term
    localparam int SUM_BITS = 2 * DATA_W + 4;
    localparam logic signed [SUM_BITS-1:0] LANE_MAX = (SUM_BITS'(1) <<< (DATA_W - 1)) - 1;
    localparam logic signed [SUM_BITS-1:0] LANE_MIN = -LANE_MAX - 1;
    localparam logic [REG_W-1:0] IDENTITY_ROWS [NUM_REGS] = '{
        REG_W'(ONE_WORD), '0, REG_W'(ONE_WORD) << WORD_W, '0, '0, REG_W'(ONE_WORD)
    };

    typedef struct packed {
        logic                              clipped;
        logic [NUM_LANES-1:0][WORD_W-1:0] lane;
    } vertex_result_t;

    logic [REG_W-1:0] matrix_words [NUM_REGS];
    vertex_result_t   expected_points [$];
    int               error_total = 0;

    function automatic vertex_result_t transform_point(logic [TDATA_W-1:0] pt);
        vertex_result_t              res;
        logic signed [SUM_BITS-1:0]  coord [NUM_LANES];
        logic signed [SUM_BITS-1:0]  cf;
        logic signed [SUM_BITS-1:0]  sum;
        logic signed [SUM_BITS-1:0]  scaled;
        logic signed [DATA_W-1:0]    narrow;
        logic signed [WORD_W-1:0]    wide;
        logic [REG_W-1:0]            row_word;
        res.clipped = 1'b0;
        for (int j = 0; j < NUM_LANES; j++)
            coord[j] = signed'(pt[j*WORD_W +: DATA_W]);
        for (int i = 0; i < NUM_LANES; i++) begin
            sum = '0;
            for (int j = 0; j < 4; j++) begin
                row_word = matrix_words[2*i + j/2];
                cf = signed'(row_word[(j % 2) * WORD_W +: DATA_W]);
                // column 3 is the translation, multiplied by w = 1.0
                if (j == 3)
                    sum += cf <<< FRAC_W;
                else
                    sum += cf * coord[j];
            end
            scaled = sum >>> FRAC_W;
            if (scaled > LANE_MAX) begin
                scaled = LANE_MAX;
                res.clipped = 1'b1;
            end else if (scaled < LANE_MIN) begin
                scaled = LANE_MIN;
                res.clipped = 1'b1;
            end
            narrow = scaled[DATA_W-1:0];
            wide = narrow;
            res.lane[i] = wide;
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        vertex_result_t want;
        string          lane_name [NUM_LANES];
        lane_name = '{"out_x", "out_y", "out_z"};
        if (!aresetn) begin
            matrix_words = IDENTITY_ROWS;
            expected_points.delete();
        end else begin
            // indexes past the last register are dropped by the block
            if (cfg_valid && cfg_ready && cfg_index < NUM_REGS)
                matrix_words[cfg_index] = cfg_data;
            if (m_tvalid && m_tready) begin
                if (expected_points.size() == 0) begin
                    $error("result transfer with no point outstanding: tdata %h", m_tdata);
                    error_total++;
                end else begin
                    want = expected_points.pop_front();
                    for (int i = 0; i < NUM_LANES; i++)
                        if (m_tdata[i*WORD_W +: WORD_W] !== want.lane[i]) begin
                            $error("%s: expected %h, got %h", lane_name[i], want.lane[i],
                                   m_tdata[i*WORD_W +: WORD_W]);
                            error_total++;
                        end
                    if (m_tuser[0] !== want.clipped) begin
                        $error("clipped: expected %b, got %b", want.clipped, m_tuser[0]);
                        error_total++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_points.push_back(transform_point(s_tdata));
        end
        mismatches     <= error_total;
        points_pending <= expected_points.size();
    end

endmodule

FILE: tb/affine_vertex_transform_core_test.sv
// ----------------------------------------------------------------------------
// affine vertex transform core test
// directed corner points, then batches of random points under random and
// extreme matrices, with bursty input and a stalling output side
// ----------------------------------------------------------------------------
module affine_vertex_transform_core_test;

    import avt_pkg::*;

    // cycles without any transfer before the run is declared hung
    localparam int IDLE_LIMIT   = 4000;
    localparam int BATCHES      = 10;
    localparam int BATCH_POINTS = 70;

    // q16.16 constants
    localparam logic [WORD_W-1:0] Q_ONE     = ONE_WORD;
    localparam logic [WORD_W-1:0] Q_HALF    = ONE_WORD >> 1;
    localparam logic [WORD_W-1:0] Q_NEG_ONE = -ONE_WORD;
    localparam logic [WORD_W-1:0] Q_MAX     = WORD_W'(DATA_MAX);
    localparam logic [WORD_W-1:0] Q_MIN     = WORD_W'(DATA_MIN);
    localparam logic [WORD_W-1:0] RAW_ONE   = WORD_W'(1);
    localparam logic [WORD_W-1:0] RAW_NEG   = '1;

    // register indexes the block must ignore
    localparam logic [CFG_IDX_W-1:0] FIRST_UNUSED_REG = CFG_IDX_W'(NUM_REGS);
    localparam logic [CFG_IDX_W-1:0] LAST_UNUSED_REG  = '1;

    // how random words are drawn
    typedef enum int {RANGE_NARROW, RANGE_FULL, RANGE_EDGE} value_range_t;

    // output side ready patterns
    typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} stall_mode_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata   = '0;   // in_x, in_y, in_z
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;          // out_x, out_y, out_z
    logic [0:0]           m_tuser;          // clipped
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [REG_W-1:0]     cfg_data  = '0;

    int          mismatches;
    int          points_pending;
    int          burst_left  = 0;
    int          idle_cycles = 0;
    stall_mode_t stall_mode  = READY_ALWAYS;
    int          stall_timer = 0;
    logic [3:0]  stall_phase = '0;

    always #2 aclk = ~aclk;

    affine_vertex_transform_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    affine_vertex_transform_core_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .points_pending (points_pending)
    );

    // receiver: switch between ready patterns whenever stall_timer runs out
    always @(posedge aclk) begin
        if (stall_timer == 0) begin
            stall_mode  <= stall_mode_t'($urandom_range(0, 3));
            stall_timer <= $urandom_range(16, 96);
        end else begin
            stall_timer <= stall_timer - 1;
        end
        stall_phase <= stall_phase + 1'b1;
        case (stall_mode)
            READY_ALWAYS: begin
                m_tready <= 1'b1;
            end
            READY_COIN: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            READY_SPARSE: begin
                m_tready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                m_tready <= stall_phase[1];
            end
        endcase
    end

    // watchdog: any transfer on any channel counts as progress
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("affine_vertex_transform_core regression: fail");
            $finish;
        end
    end

    function automatic logic [WORD_W-1:0] rand_value(value_range_t kind);
        logic [WORD_W-1:0] edge_vals [8];
        edge_vals = '{Q_MAX, Q_MIN, '0, Q_ONE, Q_NEG_ONE, RAW_NEG, RAW_ONE, $urandom};
        case (kind)
            // +/-16.0: products stay far from saturation
            RANGE_NARROW: return WORD_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
            RANGE_FULL:   return $urandom;
            default:      return edge_vals[$urandom_range(0, 7)];
        endcase
    endfunction

    // point transfer, with a random gap whenever a burst runs out
    task automatic send_point(input logic [WORD_W-1:0] x, y, z);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
                s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(1, 32);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
    endtask

    // register write; cfg_valid stays up for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic set_matrix(input logic [REG_W-1:0] r0, r1, r2, r3, r4, r5);
        logic [REG_W-1:0] words [NUM_REGS];
        words = '{r0, r1, r2, r3, r4, r5};
        for (int i = 0; i < NUM_REGS; i++)
            write_reg(cfg_reg_t'(i), words[i]);
        // now and then a write the block has to drop
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, 7)), {$urandom, $urandom});
        cfg_valid <= 1'b0;
    endtask

    // stop sending and wait until every outstanding point has come back
    task automatic drain_points();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (points_pending != 0) @(posedge aclk);
    endtask

    initial begin
        value_range_t mat_kind;
        value_range_t pt_kind;
        int           pick;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // identity after reset
        send_point('0, '0, '0);
        send_point(Q_MAX, Q_MIN, RAW_NEG);
        send_point(Q_MIN, Q_MAX, RAW_ONE);
        send_point(Q_ONE, Q_ONE << 1, -(Q_ONE * 3));
        drain_points();

        // translation at both extremes: overflow and underflow clamp
        set_matrix({WORD_W'(0), Q_ONE}, {Q_MAX, WORD_W'(0)}, {Q_ONE, WORD_W'(0)},
                   {Q_MIN, WORD_W'(0)}, '0, {WORD_W'('h12345), Q_ONE});
        send_point(RAW_ONE, RAW_NEG, '0);
        send_point(-WORD_W'(5), WORD_W'(5), WORD_W'(7));
        drain_points();

        // half scale: negative results round toward minus infinity
        set_matrix({WORD_W'(0), Q_HALF}, '0, {Q_HALF, WORD_W'(0)}, '0, '0,
                   {WORD_W'(0), Q_HALF});
        send_point(RAW_NEG, RAW_NEG, RAW_NEG);
        send_point(RAW_ONE, RAW_ONE, RAW_ONE);
        send_point(-WORD_W'('h10001), WORD_W'(3), -WORD_W'(2));
        drain_points();

        // all coefficients at the positive extreme
        set_matrix({2{Q_MAX}}, {2{Q_MAX}}, {2{Q_MAX}}, {2{Q_MAX}}, {2{Q_MAX}}, {2{Q_MAX}});
        send_point(Q_MAX, Q_MAX, Q_MAX);
        send_point(Q_MIN, Q_MIN, Q_MIN);
        send_point('0, '0, '0);
        drain_points();

        // all coefficients at the negative extreme
        set_matrix({2{Q_MIN}}, {2{Q_MIN}}, {2{Q_MIN}}, {2{Q_MIN}}, {2{Q_MIN}}, {2{Q_MIN}});
        send_point(Q_MIN, Q_MIN, Q_MIN);
        send_point(RAW_ONE, '0, '0);
        drain_points();

        // writes past the last register must leave the matrix alone
        set_matrix({WORD_W'(0), Q_ONE}, '0, {Q_ONE, WORD_W'(0)}, '0, '0,
                   {WORD_W'(0), Q_ONE});
        write_reg(FIRST_UNUSED_REG, '1);
        write_reg(LAST_UNUSED_REG, '1);
        cfg_valid <= 1'b0;
        send_point(Q_ONE, Q_ONE, Q_ONE);
        drain_points();

        // random batches, a fresh matrix for each
        for (int b = 0; b < BATCHES; b++) begin
            mat_kind = value_range_t'(b % 3);
            set_matrix({rand_value(mat_kind), rand_value(mat_kind)},
                       {rand_value(mat_kind), rand_value(mat_kind)},
                       {rand_value(mat_kind), rand_value(mat_kind)},
                       {rand_value(mat_kind), rand_value(mat_kind)},
                       {rand_value(mat_kind), rand_value(mat_kind)},
                       {rand_value(mat_kind), rand_value(mat_kind)});
            for (int n = 0; n < BATCH_POINTS; n++) begin
                pick = $urandom_range(0, 9);
                pt_kind = (pick < 5) ? RANGE_FULL : (pick < 8) ? RANGE_NARROW : RANGE_EDGE;
                send_point(rand_value(pt_kind), rand_value(pt_kind), rand_value(pt_kind));
            end
            drain_points();
        end

        // let the pipeline settle before the verdict
        repeat (PIPE_D + 4) @(posedge aclk);
        if (mismatches == 0 && points_pending == 0)
            $display("affine_vertex_transform_core regression: pass");
        else
            $display("affine_vertex_transform_core regression: fail");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/avt_pkg.sv
rtl/core/avt_lane.sv
rtl/core/avt_merge.sv
rtl/core/affine_vertex_transform_core.sv
tb/affine_vertex_transform_core_checker.sv
tb/affine_vertex_transform_core_test.sv
